[sv/wildcard_byte_pattern_search_macros.svh]
// Assertion macros for the wildcard byte pattern search block.
// Included by files that carry concurrent checks; expects clk_i and rst_ni in scope.
`ifndef WILDCARD_BYTE_PATTERN_SEARCH_MACROS_SVH
`define WILDCARD_BYTE_PATTERN_SEARCH_MACROS_SVH

// Same-cycle implication, disabled during reset
`define WBPS_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define WBPS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/wbps_pkg.sv]
// Shared types and constants of the wildcard byte pattern search block.
// No dependencies; imported by the front, queue, back and top-level modules.
package wbps_pkg;

  // Default pattern store depth
  localparam int unsigned MAX_PATTERN_DEF = 64;

  // Request queue depth between front and back
  localparam int unsigned Q_DEPTH = 2;

  // Command codes on the input tuser field
  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_APPEND = 2'd1;
  localparam logic [1:0] CMD_SOURCE = 2'd2;

  // Register indexes, taken from paddr[2]
  localparam logic REG_WC_ENABLE = 1'b0;
  localparam logic REG_WC_VALUE  = 1'b1;

  // Register reset values
  localparam logic       WC_ENABLE_RESET = 1'b1;
  localparam logic [7:0] WC_VALUE_RESET  = 8'h90;

  // Saturation point of the source offset counter
  localparam logic [31:0] POS_MAX = 32'hFFFF_FFFF;

  // Result tdata: found, match_offset[31:0], pattern_overflow, zero pad
  localparam int unsigned OUT_TDATA_W = 40;

  // Classified request kinds
  typedef enum logic [1:0] {
    OP_CLEAR,
    OP_APPEND,
    OP_SOURCE
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] data;
    logic       last;
  } req_t;

  typedef struct packed {
    logic       wc_enable;
    logic [7:0] wc_value;
  } cfg_t;

  // Back-end handshake status seen by the top-level checks
  typedef struct packed {
    logic pop;
    logic out_load;
  } bk_status_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_WAIT,
    BK_RESULT
  } bk_state_e;

endpackage

[sv/wbps_front.sv]
// Front end: accepts input items and classifies them into queue requests.
// Depends on wbps_pkg; feeds wbps_queue.
module wbps_front (
  input  logic              tvalid_i,
  input  logic [7:0]        tdata_i,   // data_byte
  input  logic [1:0]        tuser_i,   // command
  input  logic              tlast_i,   // last_byte
  output logic              tready_o,
  input  logic              q_full_i,
  output logic              push_o,
  output wbps_pkg::req_t    req_o
);
  import wbps_pkg::*;

  logic keep;
  op_e  op;

  // Map command codes; drop the unused code
  always_comb begin
    unique case (tuser_i)
      CMD_CLEAR: begin
        op   = OP_CLEAR;
        keep = 1'b1;
      end
      CMD_APPEND: begin
        op   = OP_APPEND;
        keep = 1'b1;
      end
      CMD_SOURCE: begin
        op   = OP_SOURCE;
        keep = 1'b1;
      end
      default: begin
        op   = OP_CLEAR;
        keep = 1'b0;
      end
    endcase
  end

  // Take items whenever the queue has room
  assign tready_o   = !q_full_i;
  assign push_o     = tvalid_i && !q_full_i && keep;
  assign req_o.op   = op;
  assign req_o.data = tdata_i;
  assign req_o.last = tlast_i && (op == OP_SOURCE);

endmodule

[sv/wbps_queue.sv]
// Short request queue that decouples the front end from the back end.
// Depends on wbps_pkg for the request type and depth.
module wbps_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  wbps_pkg::req_t    req_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output wbps_pkg::req_t    head_o
);
  import wbps_pkg::*;

  localparam int unsigned PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int unsigned CW = $clog2(Q_DEPTH + 1);

  req_t          ent_q [Q_DEPTH];
  logic [PW-1:0] wr_q, rd_q;
  logic [CW-1:0] cnt_q;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == CW'(Q_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign head_o  = ent_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Advance pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PW'(Q_DEPTH - 1)) ? '0 : wr_q + PW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == PW'(Q_DEPTH - 1)) ? '0 : rd_q + PW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

  // Store the request payload
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      ent_q[wr_q] <= req_i;
    end
  end

endmodule

[sv/wbps_back.sv]
// Back end: keeps the pattern memory and source window, scans one pattern byte
// per cycle and drives the registered result. Depends on wbps_pkg.
module wbps_back #(
  parameter int unsigned MAX_PATTERN = wbps_pkg::MAX_PATTERN_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  wbps_pkg::cfg_t                     cfg_i,
  input  logic                               q_valid_i,
  input  wbps_pkg::req_t                     q_req_i,
  output logic                               q_pop_o,
  output logic                               tvalid_o,
  input  logic                               tready_i,
  output logic [wbps_pkg::OUT_TDATA_W-1:0]   tdata_o,
  output wbps_pkg::bk_status_t               status_o
);
  import wbps_pkg::*;

  localparam int unsigned CW = $clog2(MAX_PATTERN + 1);
  localparam int unsigned AW = $clog2(MAX_PATTERN);
  localparam logic [CW-1:0] COUNT_MAX = CW'(MAX_PATTERN);

  bk_state_e             state_q, state_d;
  logic [CW-1:0]         count_q;
  logic                  ovf_q;
  logic [31:0]           pos_q, idx_q, offset_q;
  logic                  found_q, last_q, ok_q;
  logic [AW-1:0]         k_q;
  logic                  rd_vld_q, rd_first_q;
  logic [7:0]            rdata_q;
  logic [7:0]            win_q  [MAX_PATTERN];
  logic [7:0]            scan_q [MAX_PATTERN];
  logic [7:0]            pat_mem [MAX_PATTERN];
  logic                  out_vld_q;
  logic [OUT_TDATA_W-1:0] out_data_q;

  logic [CW-1:0] count_m1;
  logic [AW-1:0] rd_addr;
  logic          k_last, byte_ok, need_cmp, out_free, head_src;
  logic          pop, issue, judge, out_load;

  // Scan datapath helpers
  assign count_m1 = count_q - CW'(1);
  assign k_last   = (CW'(k_q) == count_m1);
  assign rd_addr  = AW'(count_m1 - CW'(k_q));
  assign byte_ok  = (rdata_q == scan_q[0]) ||
                    (cfg_i.wc_enable && (rdata_q == cfg_i.wc_value) && !rd_first_q);
  assign need_cmp = !found_q && (count_q != '0) && (pos_q >= 32'(count_m1));
  assign out_free = !out_vld_q || tready_i;
  assign head_src = q_valid_i && (q_req_i.op == OP_SOURCE);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: begin
        if (head_src) begin
          if (need_cmp) begin
            state_d = BK_SCAN;
          end else if (q_req_i.last) begin
            state_d = BK_RESULT;
          end
        end
      end
      BK_SCAN: begin
        if (k_last) begin
          state_d = BK_WAIT;
        end
      end
      BK_WAIT: begin
        state_d = last_q ? BK_RESULT : BK_IDLE;
      end
      BK_RESULT: begin
        if (out_free) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    pop      = 1'b0;
    issue    = 1'b0;
    judge    = 1'b0;
    out_load = 1'b0;
    unique case (state_q)
      BK_IDLE:   pop      = q_valid_i;
      BK_SCAN:   issue    = 1'b1;
      BK_WAIT:   judge    = 1'b1;
      BK_RESULT: out_load = out_free;
      default: ;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= BK_IDLE;
      count_q   <= '0;
      ovf_q     <= 1'b0;
      pos_q     <= '0;
      found_q   <= 1'b0;
      offset_q  <= '0;
      rd_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= issue;
      if (pop) begin
        unique case (q_req_i.op)
          OP_CLEAR: begin
            count_q <= '0;
            ovf_q   <= 1'b0;
          end
          OP_APPEND: begin
            if (count_q < COUNT_MAX) begin
              count_q <= count_q + CW'(1);
            end else begin
              ovf_q <= 1'b1;
            end
          end
          OP_SOURCE: begin
            if (pos_q != POS_MAX) begin
              pos_q <= pos_q + 32'd1;
            end
          end
          default: ;
        endcase
      end
      // Record the first window that matches
      if (judge && ok_q && byte_ok && !found_q) begin
        found_q  <= 1'b1;
        offset_q <= idx_q - 32'(count_m1);
      end
      // Restart the search once the result is loaded into the output register
      if (out_load) begin
        pos_q    <= '0;
        found_q  <= 1'b0;
        offset_q <= '0;
      end
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (tready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Pattern memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (pop && (q_req_i.op == OP_APPEND) && (count_q < COUNT_MAX)) begin
      pat_mem[count_q[AW-1:0]] <= q_req_i.data;
    end
    rdata_q <= pat_mem[rd_addr];
  end

  // Window shift line, scan copy and per-byte scan bookkeeping
  always_ff @(posedge clk_i) begin
    rd_first_q <= k_last;
    if (pop && head_src) begin
      win_q[0]  <= q_req_i.data;
      scan_q[0] <= q_req_i.data;
      for (int i = 1; i < MAX_PATTERN; i++) begin
        win_q[i]  <= win_q[i-1];
        scan_q[i] <= win_q[i-1];
      end
      idx_q  <= pos_q;
      last_q <= q_req_i.last;
    end else if (rd_vld_q) begin
      for (int i = 0; i < MAX_PATTERN - 1; i++) begin
        scan_q[i] <= scan_q[i+1];
      end
    end
    if (pop) begin
      k_q  <= '0;
      ok_q <= 1'b1;
    end else begin
      if (issue) begin
        k_q <= k_q + AW'(1);
      end
      if (rd_vld_q) begin
        ok_q <= ok_q && byte_ok;
      end
    end
    if (out_load) begin
      out_data_q <= {6'b0, ovf_q, (found_q ? offset_q : 32'd0), found_q};
    end
  end

  assign q_pop_o           = pop;
  assign tvalid_o          = out_vld_q;
  assign tdata_o           = out_data_q;
  assign status_o.pop      = pop;
  assign status_o.out_load = out_load;

endmodule

[sv/wildcard_byte_pattern_search.sv]
// Top level of the wildcard byte pattern search block: APB registers, front end,
// request queue and back end. Depends on wbps_pkg and the assertion macro header.
// Usage
//   Input stream: tuser carries the command (clear pattern, append pattern
//   byte, source byte), tdata the byte, tlast marks the final source byte.
//   Output stream: one result per final source byte, in tdata: found,
//   match_offset, pattern_overflow.
//   APB: wildcard enable at address 0, wildcard value at address 4.
// Timing
//   An accepted item enters a two-entry queue and is offered to the back end in
//   the cycle after. Clear, append and a source byte that needs no compare are
//   handled in the idle state; a compared source byte passes the scan state,
//   which reads the pattern memory one byte per cycle, and the wait state. A
//   final source byte then passes the result state to load the result register.
// Reset
//   Pattern length, overflow flag and search state clear at once; wildcard
//   enable resets to 1 and the wildcard value to 0x90. No clearing pass.
// Stall
//   A result waits in its output register; the next result due holds the back end,
//   the queue fills and s_axis_tready drops until the waiting result is taken.
`include "wildcard_byte_pattern_search_macros.svh"

module wildcard_byte_pattern_search #(
  parameter int unsigned MAX_PATTERN = wbps_pkg::MAX_PATTERN_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Input stream
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [7:0]                       s_axis_tdata,  // [7:0] data_byte
  input  logic [1:0]                       s_axis_tuser,  // [1:0] command
  input  logic                             s_axis_tlast,  // last_byte
  // Result stream
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [0] found, [32:1] match_offset, [33] pattern_overflow, [39:34] zero
  output logic [wbps_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  // Configuration
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [2:0]                       paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);
  import wbps_pkg::*;

  cfg_t       cfg_q;
  logic       cfg_wr;
  logic       reg_sel;
  logic       q_full, q_push, q_valid, q_pop;
  req_t       f_req, q_head;
  bk_status_t bk_status;

  // Register file
  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.wc_enable <= WC_ENABLE_RESET;
      cfg_q.wc_value  <= WC_VALUE_RESET;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_WC_ENABLE: cfg_q.wc_enable <= pwdata[0];
        REG_WC_VALUE:  cfg_q.wc_value  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Read back the selected register
  always_comb begin
    unique case (reg_sel)
      REG_WC_ENABLE: prdata = {31'b0, cfg_q.wc_enable};
      REG_WC_VALUE:  prdata = {24'b0, cfg_q.wc_value};
      default:       prdata = '0;
    endcase
  end

  wbps_front u_front (
    .tvalid_i (s_axis_tvalid),
    .tdata_i  (s_axis_tdata),
    .tuser_i  (s_axis_tuser),
    .tlast_i  (s_axis_tlast),
    .tready_o (s_axis_tready),
    .q_full_i (q_full),
    .push_o   (q_push),
    .req_o    (f_req)
  );

  wbps_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .req_i   (f_req),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .head_o  (q_head)
  );

  wbps_back #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .q_valid_i (q_valid),
    .q_req_i   (q_head),
    .q_pop_o   (q_pop),
    .tvalid_o  (m_axis_tvalid),
    .tready_i  (m_axis_tready),
    .tdata_o   (m_axis_tdata),
    .status_o  (bk_status)
  );

  // Checks
  `WBPS_ASSERT_IMPLY(a_pop_needs_entry, bk_status.pop, q_valid, "pop from empty request queue")
  `WBPS_ASSERT_NEXT(a_load_shows_result, bk_status.out_load, m_axis_tvalid, "loaded result not shown")
  `WBPS_ASSERT_IMPLY(a_no_result_overwrite, m_axis_tvalid && !m_axis_tready, !bk_status.out_load, "pending result overwritten")

endmodule

[verif/tb.sv]
// Testbench for wildcard_byte_pattern_search: directed rows, then random searches
// checked against an in-bench search predictor. Depends on wbps_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb;
  import wbps_pkg::*;

  localparam int unsigned PAT_DEPTH   = MAX_PATTERN_DEF;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned RAND_ITEMS  = 1900;
  localparam int unsigned NUM_PHASES  = 6;
  localparam int unsigned SETTLE      = 200;
  localparam logic [1:0]  CMD_UNUSED  = 2'd3;
  localparam int unsigned NUM_ROWS    = 27;

  typedef struct packed {
    logic        found;
    logic [31:0] offset;
    logic        overflow;
  } search_result_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  data;
    logic        last;
    logic [7:0]  reps;
    logic        typed;
    logic        found;
    logic [31:0] offset;
    logic        overflow;
  } stim_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  wildcard_byte_pattern_search u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // Predictor state: pattern, search progress and register copies
  logic [7:0]  pat_mem [PAT_DEPTH];
  int unsigned pat_len;
  logic        pat_ovf;
  logic [7:0]  src_win [PAT_DEPTH];
  logic [31:0] src_pos;
  logic        hit_seen;
  logic [31:0] hit_off;
  logic        cfg_wc_en;
  logic [7:0]  cfg_wc_val;

  search_result_t expected_reports [$];
  search_result_t want_report;
  search_result_t typed_report;
  logic           use_typed;

  int unsigned mismatch_count;
  int unsigned cycle_count;
  int unsigned request_count;
  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;

  // Byte alphabet of the current search
  int unsigned sym_mode;
  logic [7:0]  sym_a;
  logic [7:0]  sym_b;

  stim_row_t directed_rows [NUM_ROWS] = '{
    // empty pattern right after reset
    '{CMD_SOURCE, 8'h00, 1'b1, 8'd1, 1'b1, 1'b0, 32'd0, 1'b0},
    // unused command and a last mark on a clear: no result
    '{CMD_UNUSED, 8'hFF, 1'b1, 8'd1, 1'b0, 1'b0, 32'd0, 1'b0},
    '{CMD_CLEAR,  8'hFF, 1'b1, 8'd1, 1'b0, 1'b0, 32'd0, 1'b0},
    // pattern with a wildcard in the middle, hit at offset zero
    '{CMD_APPEND, 8'h41, 1'b0, 8'd1, 1'b0, 1'b0, 32'd0, 1'b0},
    '{CMD_APPEND, 8'h90, 1'b0, 8'd1, 1'b0, 1'b0, 32'd0, 1'b0},
    '{CMD_APPEND, 8'h43, 1'b1, 8'd1, 1'b0, 1'b0, 32'd0, 1'b0},
    '{CMD_SOURCE, 8'h41, 1'b0, 8'd1, 1'b0, 1'b0, 32'd0, 1'b0},
    '{CMD_SOURCE, 8'h00, 1'b0, 8'd1, 1'b0, 1'b0, 32'd0, 1'b0},
    '{CMD_SOURCE, 8'h43, 1'b1, 8'd1, 1'b1, 1'b1, 32'd0, 1'b0},
    // source shorter than the pattern
    '{CMD_SOURCE, 8'h41, 1'b0, 8'd1, 1'b0, 1'b0, 32'd0, 1'b0},
    '{CMD_SOURCE, 8'hFF, 1'b1, 8'd1, 1'b1, 1'b0, 32'd0, 1'b0},
    // wildcard in the first position must match exactly
    '{CMD_CLEAR,  8'h00, 1'b0, 8'd1, 1'b0, 1'b0, 32'd0, 1'b0},
    '{CMD_APPEND, 8'h90, 1'b0, 8'd1, 1'b0, 1'b0, 32'd0, 1'b0},
    '{CMD_APPEND, 8'hFF, 1'b0, 8'd1, 1'b0, 1'b0, 32'd0, 1'b0},
    '{CMD_SOURCE, 8'h00, 1'b0, 8'd1, 1'b0, 1'b0, 32'd0, 1'b0},
    '{CMD_SOURCE, 8'hFF, 1'b1, 8'd1, 1'b1, 1'b0, 32'd0, 1'b0},
    '{CMD_SOURCE, 8'h90, 1'b0, 8'd1, 1'b0, 1'b0, 32'd0, 1'b0},
    '{CMD_SOURCE, 8'hFF, 1'b1, 8'd1, 1'b1, 1'b1, 32'd0, 1'b0},
    // append between source bytes
    '{CMD_SOURCE, 8'h90, 1'b0, 8'd1, 1'b0, 1'b0, 32'd0, 1'b0},
    '{CMD_APPEND, 8'h00, 1'b0, 8'd1, 1'b0, 1'b0, 32'd0, 1'b0},
    '{CMD_SOURCE, 8'hFF, 1'b0, 8'd1, 1'b0, 1'b0, 32'd0, 1'b0},
    '{CMD_SOURCE, 8'h00, 1'b1, 8'd1, 1'b0, 1'b0, 32'd0, 1'b0},
    // overflow the pattern store, then search the full store
    '{CMD_CLEAR,  8'h00, 1'b0, 8'd1, 1'b0, 1'b0, 32'd0, 1'b0},
    '{CMD_APPEND, 8'hAA, 1'b0, 8'd65, 1'b0, 1'b0, 32'd0, 1'b0},
    '{CMD_SOURCE, 8'hAA, 1'b1, 8'd64, 1'b1, 1'b1, 32'd0, 1'b1},
    // clear drops the overflow flag
    '{CMD_CLEAR,  8'h00, 1'b0, 8'd1, 1'b0, 1'b0, 32'd0, 1'b0},
    '{CMD_SOURCE, 8'h5A, 1'b1, 8'd1, 1'b1, 1'b0, 32'd0, 1'b0}
  };

  // Clock and run limit
  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch at %0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // Compare the newest pat_len window bytes with the stored pattern
  function automatic logic window_hit();
    if (src_win[pat_len-1] != pat_mem[0]) return 1'b0;
    for (int unsigned j = 1; j < pat_len; j++) begin
      if (cfg_wc_en && pat_mem[j] == cfg_wc_val) continue;
      if (src_win[pat_len-1-j] != pat_mem[j]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Advance the predictor by one request; returns 1 when a result is due
  function automatic logic search_step(input logic [1:0] cmd, input logic [7:0] data,
                                       input logic last, output search_result_t res);
    logic [31:0] idx;
    res = '0;
    case (cmd)
      CMD_CLEAR: begin
        pat_len = 0;
        pat_ovf = 1'b0;
      end
      CMD_APPEND: begin
        if (pat_len < PAT_DEPTH) begin
          pat_mem[pat_len] = data;
          pat_len++;
        end else begin
          pat_ovf = 1'b1;
        end
      end
      CMD_SOURCE: begin
        for (int i = PAT_DEPTH - 1; i > 0; i--) src_win[i] = src_win[i-1];
        src_win[0] = data;
        idx = src_pos;
        if (src_pos != POS_MAX) src_pos++;
        if (!hit_seen && pat_len != 0 && idx >= 32'(pat_len - 1) && window_hit()) begin
          hit_seen = 1'b1;
          hit_off  = idx - 32'(pat_len - 1);
        end
        if (last) begin
          res.found    = hit_seen;
          res.offset   = hit_seen ? hit_off : 32'd0;
          res.overflow = pat_ovf;
          for (int i = 0; i < PAT_DEPTH; i++) src_win[i] = 8'h00;
          src_pos  = '0;
          hit_seen = 1'b0;
          hit_off  = '0;
          return 1'b1;
        end
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  // Send one request; called and returning at a falling edge
  task automatic send_request(input logic [1:0] cmd, input logic [7:0] data,
                              input logic last);
    search_result_t res;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    s_axis_tuser  <= cmd;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    if (search_step(cmd, data, last, res))
      expected_reports.insert(expected_reports.size(), use_typed ? typed_report : res);
    use_typed = 1'b0;
    if (cmd != CMD_UNUSED) request_count++;
    @(negedge clk_i);
  endtask

  // One APB transfer, then an idle wait with psel low
  task automatic apb_access(input logic wr, input logic [2:0] addr,
                            input logic [31:0] wdata, output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  // Write both registers and read them back
  task automatic set_wildcard(input logic en, input logic [7:0] val);
    logic [31:0] rd;
    apb_access(1'b1, {REG_WC_ENABLE, 2'b00}, {31'd0, en}, rd);
    apb_access(1'b0, {REG_WC_ENABLE, 2'b00}, 32'd0, rd);
    if (rd != {31'd0, en}) report_mismatch("wildcard enable readback", rd, {31'd0, en});
    apb_access(1'b1, {REG_WC_VALUE, 2'b00}, {24'd0, val}, rd);
    apb_access(1'b0, {REG_WC_VALUE, 2'b00}, 32'd0, rd);
    if (rd != {24'd0, val}) report_mismatch("wildcard value readback", rd, {24'd0, val});
    cfg_wc_en  = en;
    cfg_wc_val = val;
  endtask

  // Hold the sender until every result is back and the block has settled
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  function automatic logic [7:0] pick_byte();
    case (sym_mode)
      0:       return 8'($urandom_range(0, 255));
      1:       return $urandom_range(0, 1) ? sym_a : sym_b;
      default: return $urandom_range(0, 2) == 0 ? cfg_wc_val : sym_a;
    endcase
  endfunction

  // One search: optional clear, pattern load, source run with noise
  task automatic run_search();
    int unsigned n;
    int unsigned m;
    int unsigned stored;
    int unsigned plant_at;
    int unsigned r;
    logic        plant;
    logic [7:0]  b;
    logic [7:0]  plant_bytes [PAT_DEPTH];
    sym_mode = $urandom_range(0, 2);
    sym_a    = 8'($urandom_range(0, 255));
    sym_b    = sym_a ^ (8'h01 << $urandom_range(0, 7));
    if ($urandom_range(0, 7) != 0)
      send_request(CMD_CLEAR, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    r = $urandom_range(0, 99);
    n = (r < 4) ? 0 : (r < 80) ? $urandom_range(1, 4) :
        (r < 96) ? $urandom_range(5, 12) : $urandom_range(60, 68);
    for (int unsigned i = 0; i < n; i++) begin
      b = ($urandom_range(0, 3) == 0) ? cfg_wc_val : pick_byte();
      send_request(CMD_APPEND, b, 1'($urandom_range(0, 1)));
    end
    // plant the stored pattern so that hits are common
    stored = pat_len;
    for (int unsigned i = 0; i < stored; i++) plant_bytes[i] = pat_mem[i];
    plant = (stored != 0) && ($urandom_range(0, 2) != 0);
    m = $urandom_range(1, 20);
    if (plant && m < stored) m = stored + $urandom_range(0, 6);
    plant_at = plant ? $urandom_range(0, m - stored) : 0;
    for (int unsigned k = 0; k < m; k++) begin
      if ($urandom_range(0, 39) == 0)
        send_request(CMD_UNUSED, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      if ($urandom_range(0, 59) == 0)
        send_request(CMD_APPEND, pick_byte(), 1'b0);
      if ($urandom_range(0, 149) == 0)
        send_request(CMD_CLEAR, 8'h00, 1'b0);
      b = pick_byte();
      if (plant && k >= plant_at && k < plant_at + stored) begin
        b = plant_bytes[k - plant_at];
        if (k > plant_at && cfg_wc_en && b == cfg_wc_val && $urandom_range(0, 1))
          b = 8'($urandom_range(0, 255));
      end
      send_request(CMD_SOURCE, b, k == m - 1);
    end
  endtask

  // Result checker
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_reports.size() == 0) begin
        report_mismatch("result with none pending", m_axis_tdata[31:0], 32'd0);
      end else begin
        want_report = expected_reports.pop_front();
        if (m_axis_tdata[0] != want_report.found)
          report_mismatch("found", 32'(m_axis_tdata[0]), 32'(want_report.found));
        if (m_axis_tdata[32:1] != want_report.offset)
          report_mismatch("match_offset", m_axis_tdata[32:1], want_report.offset);
        if (m_axis_tdata[33] != want_report.overflow)
          report_mismatch("pattern_overflow", 32'(m_axis_tdata[33]),
                          32'(want_report.overflow));
      end
    end
  end

  // Receiver stalls
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  initial begin
    logic [31:0] rd;
    int unsigned phase_target;
    rst_ni         = 1'b0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tuser   = CMD_CLEAR;
    s_axis_tlast   = 1'b0;
    m_axis_tready  = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    mismatch_count = 0;
    cycle_count    = 0;
    request_count  = 0;
    use_typed      = 1'b0;
    typed_report   = '0;
    tx_idle_pct    = 38;
    rx_idle_pct    = 66;
    pat_len        = 0;
    pat_ovf        = 1'b0;
    src_pos        = '0;
    hit_seen       = 1'b0;
    hit_off        = '0;
    cfg_wc_en      = WC_ENABLE_RESET;
    cfg_wc_val     = WC_VALUE_RESET;
    for (int i = 0; i < PAT_DEPTH; i++) begin
      pat_mem[i] = 8'h00;
      src_win[i] = 8'h00;
    end

    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Registers come up at their reset values
    apb_access(1'b0, {REG_WC_ENABLE, 2'b00}, 32'd0, rd);
    if (rd != {31'd0, WC_ENABLE_RESET})
      report_mismatch("wildcard enable after reset", rd, {31'd0, WC_ENABLE_RESET});
    apb_access(1'b0, {REG_WC_VALUE, 2'b00}, 32'd0, rd);
    if (rd != {24'd0, WC_VALUE_RESET})
      report_mismatch("wildcard value after reset", rd, {24'd0, WC_VALUE_RESET});

    // Directed rows
    for (int unsigned r = 0; r < NUM_ROWS; r++) begin
      for (int unsigned k = 0; k < directed_rows[r].reps; k++) begin
        use_typed    = directed_rows[r].typed && (k == directed_rows[r].reps - 1);
        typed_report = '{directed_rows[r].found, directed_rows[r].offset,
                         directed_rows[r].overflow};
        send_request(directed_rows[r].cmd, directed_rows[r].data,
                     directed_rows[r].last && (k == directed_rows[r].reps - 1));
      end
    end
    drain();

    // Random phases: each with its own register setting; the idling mix changes every two phases
    request_count = 0;
    for (int unsigned p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: set_wildcard(1'b1, 8'h90);
        1: set_wildcard(1'b0, 8'h90);
        2: set_wildcard(1'b1, 8'h00);
        3: set_wildcard(1'b1, 8'hFF);
        4: set_wildcard(1'b0, 8'h00);
        default: set_wildcard(1'b1, 8'($urandom_range(0, 255)));
      endcase
      tx_idle_pct = (p < 2) ? 38 : (p < 4) ? 66 : 0;
      rx_idle_pct = (p < 2) ? 66 : (p < 4) ? 38 : 0;
      phase_target = (p + 1) * RAND_ITEMS / NUM_PHASES;
      while (request_count < phase_target) run_search();
      drain();
    end

    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+sv
sv/wbps_pkg.sv
sv/wbps_front.sv
sv/wbps_queue.sv
sv/wbps_back.sv
sv/wildcard_byte_pattern_search.sv
verif/tb.sv
